>>> rtl/core/rbwi_pkg.sv
// Shared types, register codes and saturating Q16.16 arithmetic helpers
// for the rigid body world inertia transform. No dependencies.
`default_nettype none

package rbwi_pkg;

	typedef logic signed [31:0] word_t;
	typedef logic [2:0][31:0] vec3_t;
	typedef logic [2:0][2:0][31:0] mat_t;

	localparam int unsigned REG_IDX_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_XX = 3'd0,
		REG_XY = 3'd1,
		REG_XZ = 3'd2,
		REG_YY = 3'd3,
		REG_YZ = 3'd4,
		REG_ZZ = 3'd5
	} reg_idx_t;

	localparam word_t Q_ONE = 32'sd65536;
	localparam word_t W_MAX = 32'sh7fffffff;
	localparam word_t W_MIN = 32'sh80000000;
	localparam logic signed [63:0] WIDE_MAX = 64'sd2147483647;
	localparam logic signed [63:0] WIDE_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [31:0] quat_w;
		logic [31:0] quat_x;
		logic [31:0] quat_y;
		logic [31:0] quat_z;
		logic [31:0] pos_x;
		logic [31:0] pos_y;
		logic [31:0] pos_z;
	} item_t;

	typedef struct packed {
		logic [1:0]  row_index;
		logic [31:0] rot_c0;
		logic [31:0] rot_c1;
		logic [31:0] rot_c2;
		logic [31:0] translation;
		logic [31:0] inertia_c0;
		logic [31:0] inertia_c1;
		logic [31:0] inertia_c2;
		logic        final_row;
	} result_t;

	// Row context that travels beside the tensor arithmetic.
	typedef struct packed {
		logic [1:0]  row;
		mat_t        rot;
		logic [31:0] trans;
	} side_t;

	function automatic word_t sat_wide(input logic signed [63:0] v);
		if (v > WIDE_MAX) return W_MAX;
		else if (v < WIDE_MIN) return W_MIN;
		else return v[31:0];
	endfunction

	function automatic word_t sat33(input logic [32:0] s);
		if (s[32] != s[31]) return s[32] ? W_MIN : W_MAX;
		else return s[31:0];
	endfunction

	function automatic word_t qadd(input word_t a, input word_t b);
		return sat33({a[31], a} + {b[31], b});
	endfunction

	function automatic word_t qsub(input word_t a, input word_t b);
		return sat33({a[31], a} - {b[31], b});
	endfunction

	// Arithmetic shift floors the product, then the result saturates.
	function automatic word_t qmul(input word_t a, input word_t b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return sat_wide(p >>> 16);
	endfunction

	function automatic word_t twice(input word_t a, input word_t b);
		word_t m;
		m = qmul(a, b);
		return qadd(m, m);
	endfunction

endpackage

`default_nettype wire

>>> rtl/core/rbwi_dot3.sv
// Two-stage saturating three-term dot product, (a0*b0 + a1*b1) + a2*b2.
// Depends on rbwi_pkg.
`default_nettype none

module rbwi_dot3 import rbwi_pkg::*; (
	input  wire logic  clk,
	input  wire logic  en,
	input  wire vec3_t a,
	input  wire vec3_t b,
	output word_t      sum
);

	vec3_t prod_s1;
	word_t sum_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				prod_s1[k] <= qmul(a[k], b[k]);
			end
			sum_s2 <= qadd(qadd(prod_s1[0], prod_s1[1]), prod_s1[2]);
		end
	end

	assign sum = sum_s2;

endmodule

`default_nettype wire

>>> rtl/core/rigid_body_world_inertia_transform_top.sv
// Top level of the rigid body world inertia transform.
// Depends on rbwi_pkg and rbwi_dot3.
// Each accepted request gives three result rows, one row per cycle while the
// result channel does not stall; stage 2 holds a request until its third
// row has moved on into stage 3, so the result channel sets the request rate.
// Reset clears all valid bits and the row counter and loads the body tensor
// registers with the identity; payload registers are not reset.
`default_nettype none

module rigid_body_world_inertia_transform_top import rbwi_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 item_valid,
	output logic                      item_stall,
	input  wire item_t                item,
	output logic                      result_valid,
	input  wire logic                 result_stall,
	output result_t                   result,
	input  wire logic                 wr_en,
	input  wire logic [REG_IDX_W-1:0] wr_index,
	input  wire logic [31:0]          wr_data
);

	// Body tensor registers; the user must write them only while the block is idle, as the block does not enforce it.
	word_t xx_q, xy_q, xz_q, yy_q, yz_q, zz_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xx_q <= Q_ONE;
			xy_q <= '0;
			xz_q <= '0;
			yy_q <= Q_ONE;
			yz_q <= '0;
			zz_q <= Q_ONE;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_XX:  xx_q <= wr_data;
				REG_XY:  xy_q <= wr_data;
				REG_XZ:  xz_q <= wr_data;
				REG_YY:  yy_q <= wr_data;
				REG_YZ:  yz_q <= wr_data;
				REG_ZZ:  zz_q <= wr_data;
				default: ;
			endcase
		end
	end

	// The row pipeline (stages 3 to 6) moves as one whenever the result
	// register is empty or being taken.
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic [1:0] cnt_q;
	logic adv, s1_free, s2_free;

	assign adv     = !vld_s6 || !result_stall;
	assign s2_free = !vld_s2 || (adv && cnt_q == 2'd2);
	assign s1_free = !vld_s1 || s2_free;
	assign item_stall = !s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (s1_free) vld_s1 <= item_valid;
			if (s2_free) vld_s2 <= vld_s1;
			if (adv) begin
				vld_s3 <= vld_s2;
				vld_s4 <= vld_s3;
				vld_s5 <= vld_s4;
				vld_s6 <= vld_s5;
				if (vld_s2) cnt_q <= (cnt_q == 2'd2) ? 2'd0 : cnt_q + 2'd1;
			end
		end
	end

	// Stage 1: the nine doubled quaternion products, and the position.
	word_t xx_s1, yy_s1, zz_s1, xy_s1, xz_s1, yz_s1, wx_s1, wy_s1, wz_s1;
	vec3_t pos_s1;

	always_ff @(posedge clk) begin
		if (s1_free) begin
			xx_s1 <= twice(item.quat_x, item.quat_x);
			yy_s1 <= twice(item.quat_y, item.quat_y);
			zz_s1 <= twice(item.quat_z, item.quat_z);
			xy_s1 <= twice(item.quat_x, item.quat_y);
			xz_s1 <= twice(item.quat_x, item.quat_z);
			yz_s1 <= twice(item.quat_y, item.quat_z);
			wx_s1 <= twice(item.quat_w, item.quat_x);
			wy_s1 <= twice(item.quat_w, item.quat_y);
			wz_s1 <= twice(item.quat_w, item.quat_z);
			pos_s1 <= {item.pos_z, item.pos_y, item.pos_x};
		end
	end

	// Stage 2: the rotation matrix. The request stays here until all three of its rows
	// have been sent down, one after another.
	mat_t  rot_s2;
	vec3_t pos_s2;

	always_ff @(posedge clk) begin
		if (s2_free) begin
			rot_s2[0][0] <= qsub(qsub(Q_ONE, yy_s1), zz_s1);
			rot_s2[0][1] <= qsub(xy_s1, wz_s1);
			rot_s2[0][2] <= qadd(xz_s1, wy_s1);
			rot_s2[1][0] <= qadd(xy_s1, wz_s1);
			rot_s2[1][1] <= qsub(qsub(Q_ONE, xx_s1), zz_s1);
			rot_s2[1][2] <= qsub(yz_s1, wx_s1);
			rot_s2[2][0] <= qsub(xz_s1, wy_s1);
			rot_s2[2][1] <= qadd(yz_s1, wx_s1);
			rot_s2[2][2] <= qsub(qsub(Q_ONE, xx_s1), yy_s1);
			pos_s2 <= pos_s1;
		end
	end

	// Stages 3 and 4: one row of T = R * B. The body tensor is symmetric,
	// so each column equals the matching row.
	vec3_t bcol [3];
	vec3_t t_row;

	assign bcol[0] = {xz_q, xy_q, xx_q};
	assign bcol[1] = {yz_q, yy_q, xy_q};
	assign bcol[2] = {zz_q, yz_q, xz_q};

	for (genvar c = 0; c < 3; c++) begin : g_t
		rbwi_dot3 u_dot (
			.clk (clk),
			.en  (adv),
			.a   (rot_s2[cnt_q]),
			.b   (bcol[c]),
			.sum (t_row[c])
		);
	end

	side_t side_s3, side_s4, side_s5, side_s6;

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s3 <= '{row: cnt_q, rot: rot_s2, trans: pos_s2[cnt_q]};
			side_s4 <= side_s3;
			side_s5 <= side_s4;
			side_s6 <= side_s5;
		end
	end

	// Stages 5 and 6: one row of W = T * R^T, landing in the result register.
	vec3_t w_row;

	for (genvar j = 0; j < 3; j++) begin : g_w
		rbwi_dot3 u_dot (
			.clk (clk),
			.en  (adv),
			.a   (t_row),
			.b   (side_s4.rot[j]),
			.sum (w_row[j])
		);
	end

	assign result_valid       = vld_s6;
	assign result.row_index   = side_s6.row;
	assign result.rot_c0      = side_s6.rot[side_s6.row][0];
	assign result.rot_c1      = side_s6.rot[side_s6.row][1];
	assign result.rot_c2      = side_s6.rot[side_s6.row][2];
	assign result.translation = side_s6.trans;
	assign result.inertia_c0  = w_row[0];
	assign result.inertia_c1  = w_row[1];
	assign result.inertia_c2  = w_row[2];
	assign result.final_row   = (side_s6.row == 2'd2);

	// The row counter never reaches the unused code.
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("row counter out of range");

	// An accepted request always lands in stage 1.
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall |=> vld_s1) else $error("request lost");

	// Rows leave in order: a row other than the last is followed by the next.
	a_row_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && adv && side_s3.row != 2'd2 |=> vld_s4 && vld_s3 &&
		side_s3.row == $past(side_s3.row) + 2'd1) else $error("row order broken");

	// Stage 2 is never refilled before its third row has gone.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && cnt_q != 2'd2 |=> vld_s2 && $stable(rot_s2))
		else $error("rotation replaced early");

endmodule

`default_nettype wire
